/* src/s2i_pkg.sv */
// Shared constants and character decode helpers for string_to_integer_radix.
// No dependencies.
`default_nettype none

package s2i_pkg;

  // Default cell width, in bits (sign included)
  localparam int CELL_BITS_DEF = 32;

  localparam int CHAR_W  = 8;
  localparam int RADIX_W = 6;
  localparam int VALUE_W = 32;
  localparam int DIGIT_W = 7;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
  localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UC_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UC_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LC_Z  = 8'h7A;

  localparam logic [DIGIT_W-1:0] LETTER_BASE = 7'd10;
  // Larger than any radix the register can hold
  localparam logic [DIGIT_W-1:0] NOT_DIGIT   = 7'd99;

  function automatic logic is_space(input logic [CHAR_W-1:0] ch);
    return (ch == CH_TAB) || (ch == CH_CR) || (ch == CH_FF) ||
           (ch == CH_VT) || (ch == CH_LF) || (ch == CH_SPACE);
  endfunction

  function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] ch);
    logic [CHAR_W-1:0] diff;
    logic [DIGIT_W-1:0] res;
    res = NOT_DIGIT;
    diff = '0;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      diff = ch - CH_ZERO;
      res = diff[DIGIT_W-1:0];
    end else if (ch >= CH_UC_A && ch <= CH_UC_Z) begin
      diff = ch - CH_UC_A;
      res = diff[DIGIT_W-1:0] + LETTER_BASE;
    end else if (ch >= CH_LC_A && ch <= CH_LC_Z) begin
      diff = ch - CH_LC_A;
      res = diff[DIGIT_W-1:0] + LETTER_BASE;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* src/string_to_integer_radix.sv */
// A terminator's result is registered in the output register or skid entry. Input
// takes one character per cycle unless stalled; the parse state advances on every
// accepted request via one accumulator*radix multiply-add and a limit compare.
// A two-entry output (register plus skid) stalls input only while both are full.
// Reset (rst_n low, synchronous): parser idle, radix 10, no pending results.
// Depends on s2i_pkg.
`default_nettype none

module string_to_integer_radix #(
  parameter int CELL_BITS = s2i_pkg::CELL_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [s2i_pkg::RADIX_W-1:0]       cfg_radix,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [s2i_pkg::CHAR_W-1:0]        in_char_code,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [s2i_pkg::VALUE_W-1:0]     out_value,
  output logic                                   out_bad
);

  localparam int AW = CELL_BITS - 1;
  localparam int PW = AW + s2i_pkg::RADIX_W + 1;
  localparam int VW = (CELL_BITS > s2i_pkg::VALUE_W) ? CELL_BITS : s2i_pkg::VALUE_W;
  localparam logic [PW-1:0] MAG_LIMIT = PW'({AW{1'b1}});
  localparam logic [VW-1:0] ERR_VAL  = {VW{1'b1}} << AW;

  localparam logic [1:0] PH_SPACE  = 2'd0;
  localparam logic [1:0] PH_PLUS   = 2'd1;
  localparam logic [1:0] PH_MINUS  = 2'd2;
  localparam logic [1:0] PH_DIGITS = 2'd3;

  logic [s2i_pkg::RADIX_W-1:0] radix_r;
  logic [1:0]                  phase_r, phase_nxt;
  logic                        neg_r, neg_nxt;
  logic [AW-1:0]               acc_r, acc_nxt;
  logic                        failed_r, failed_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [s2i_pkg::VALUE_W-1:0] out_value_r, out_value_nxt;
  logic                        out_bad_r, out_bad_nxt;
  logic                        skid_valid_r, skid_valid_nxt;
  logic [s2i_pkg::VALUE_W-1:0] skid_value_r, skid_value_nxt;
  logic                        skid_bad_r, skid_bad_nxt;

  logic                        in_take, is_term, out_take;
  logic [s2i_pkg::DIGIT_W-1:0] digit;
  logic [PW-2:0]               prod;
  logic [PW-1:0]               sum;
  logic                        digit_bad;
  logic                        res_bad;
  logic [VW-1:0]               res_full;
  logic [s2i_pkg::VALUE_W-1:0] res_value;

  assign in_stall = skid_valid_r;
  assign in_take  = in_valid && !in_stall;
  assign is_term  = (in_char_code == s2i_pkg::CH_NUL);
  assign out_take = out_valid_r && !out_stall;

  assign digit = s2i_pkg::digit_of(in_char_code);
  assign prod  = acc_r * radix_r;
  assign sum   = {1'b0, prod} + PW'(digit);
  assign digit_bad = (digit >= {1'b0, radix_r}) || (sum > MAG_LIMIT);

  // Result of a terminator, from the state before it
  always_comb begin
    res_bad = failed_r || (phase_r != PH_DIGITS);
    if (res_bad) begin
      res_full = ERR_VAL;
    end else if (neg_r) begin
      res_full = VW'(0) - {{(VW-AW){1'b0}}, acc_r};
    end else begin
      res_full = {{(VW-AW){1'b0}}, acc_r};
    end
    res_value = res_full[s2i_pkg::VALUE_W-1:0];
  end

  // Parser state
  always_comb begin
    logic take_d;
    take_d     = 1'b0;
    phase_nxt  = phase_r;
    neg_nxt    = neg_r;
    acc_nxt    = acc_r;
    failed_nxt = failed_r;
    if (in_take) begin
      if (is_term) begin
        phase_nxt  = PH_SPACE;
        neg_nxt    = 1'b0;
        acc_nxt    = '0;
        failed_nxt = 1'b0;
      end else begin
        case (phase_r)
          PH_SPACE: begin
            if (s2i_pkg::is_space(in_char_code)) begin
              // stay
            end else if (in_char_code == s2i_pkg::CH_PLUS) begin
              phase_nxt = PH_PLUS;
            end else if (in_char_code == s2i_pkg::CH_MINUS) begin
              phase_nxt = PH_MINUS;
              neg_nxt   = 1'b1;
            end else begin
              take_d = 1'b1;
            end
          end
          PH_PLUS: begin
            if (in_char_code == s2i_pkg::CH_MINUS) begin
              phase_nxt = PH_MINUS;
              neg_nxt   = 1'b1;
            end else begin
              take_d = 1'b1;
            end
          end
          default: begin
            take_d = 1'b1;
          end
        endcase
        // Once failed, drop the rest of the string
        if (take_d && !failed_r) begin
          phase_nxt = PH_DIGITS;
          if (digit_bad) begin
            failed_nxt = 1'b1;
          end else begin
            acc_nxt = sum[AW-1:0];
          end
        end
      end
    end
  end

  // Output register plus one skid entry
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_bad_nxt    = out_bad_r;
    skid_valid_nxt = skid_valid_r;
    skid_value_nxt = skid_value_r;
    skid_bad_nxt   = skid_bad_r;
    if (skid_valid_r) begin
      if (out_take) begin
        out_value_nxt  = skid_value_r;
        out_bad_nxt    = skid_bad_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (in_take && is_term) begin
      if (!out_valid_r || out_take) begin
        out_valid_nxt = 1'b1;
        out_value_nxt = res_value;
        out_bad_nxt   = res_bad;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_value_nxt = res_value;
        skid_bad_nxt   = res_bad;
      end
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r      <= s2i_pkg::RADIX_RESET;
      phase_r      <= PH_SPACE;
      neg_r        <= 1'b0;
      acc_r        <= '0;
      failed_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        radix_r <= cfg_radix;
      end
      phase_r      <= phase_nxt;
      neg_r        <= neg_nxt;
      acc_r        <= acc_nxt;
      failed_r     <= failed_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_bad_r    <= out_bad_nxt;
    skid_value_r <= skid_value_nxt;
    skid_bad_r   <= skid_bad_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_bad   = out_bad_r;

endmodule

`default_nettype wire

/* bench/string_to_integer_radix_tb.sv */
// Self-checking bench for string_to_integer_radix: streams character requests, predicts
// each terminator's conversion result and compares it with the block's output.
// Depends on s2i_pkg and the string_to_integer_radix RTL.
module string_to_integer_radix_tb;

  localparam int CLK_HALF = 6;
  localparam int CYCLE_LIMIT = 500000;
  localparam logic [63:0] MAG_MAX = 64'h0000_0000_7FFF_FFFF;
  localparam logic [31:0] ERR_VALUE = 32'h8000_0000;
  localparam logic [6:0] NO_SYMBOL = 7'd99;
  localparam logic [7:0] CH_ONE_HELPER = 8'h31;

  typedef enum logic [1:0] {PH_SPACE, PH_PLUS, PH_MINUS, PH_DIGITS} parse_phase_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               bad;
  } conv_result_t;

  logic                               clk;
  logic                               rst_n;
  logic                               cfg_we;
  logic [s2i_pkg::RADIX_W-1:0]        cfg_radix;
  logic                               in_valid;
  logic                               in_stall;
  logic [s2i_pkg::CHAR_W-1:0]         in_char_code;
  logic                               out_valid;
  logic                               out_stall;
  logic signed [s2i_pkg::VALUE_W-1:0] out_value;
  logic                               out_bad;

  // parser state as the bench sees it
  parse_phase_t                ps_phase;
  logic                        ps_neg;
  logic [63:0]                 ps_mag;
  logic                        ps_failed;
  logic [s2i_pkg::RADIX_W-1:0] cur_radix;

  conv_result_t pending_results[$];
  int           mismatches;
  int           chars_sent;
  bit           tx_calm;
  bit           rx_calm;
  int           rx_hold_left;

  string_to_integer_radix u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_radix    (cfg_radix),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_code (in_char_code),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_value    (out_value),
    .out_bad      (out_bad)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("** string_to_integer_radix: FAILED **");
    $finish;
  end

  function automatic logic [6:0] sym_value(input logic [7:0] ch);
    if (ch >= s2i_pkg::CH_ZERO && ch <= s2i_pkg::CH_NINE) begin
      return 7'(ch - s2i_pkg::CH_ZERO);
    end else if (ch >= s2i_pkg::CH_UC_A && ch <= s2i_pkg::CH_UC_Z) begin
      return 7'(ch - s2i_pkg::CH_UC_A) + 7'd10;
    end else if (ch >= s2i_pkg::CH_LC_A && ch <= s2i_pkg::CH_LC_Z) begin
      return 7'(ch - s2i_pkg::CH_LC_A) + 7'd10;
    end
    return NO_SYMBOL;
  endfunction

  function automatic bit is_blank(input logic [7:0] ch);
    case (ch)
      s2i_pkg::CH_TAB, s2i_pkg::CH_LF, s2i_pkg::CH_VT, s2i_pkg::CH_FF, s2i_pkg::CH_CR,
      s2i_pkg::CH_SPACE: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 5))
      0: return s2i_pkg::CH_TAB;
      1: return s2i_pkg::CH_LF;
      2: return s2i_pkg::CH_VT;
      3: return s2i_pkg::CH_FF;
      4: return s2i_pkg::CH_CR;
      default: return s2i_pkg::CH_SPACE;
    endcase
  endfunction

  // Digit value to a character; letters come in either case
  function automatic logic [7:0] digit_sym(input int unsigned v);
    if (v < 10) begin
      return s2i_pkg::CH_ZERO + 8'(v);
    end
    return ($urandom_range(0, 1) ? s2i_pkg::CH_UC_A : s2i_pkg::CH_LC_A) + 8'(v - 10);
  endfunction

  function automatic int unsigned symbol_count(input logic [s2i_pkg::RADIX_W-1:0] r);
    if (r == 0) begin
      return 1;
    end
    return (r > 36) ? 36 : r;
  endfunction

  // Digits needed to pass the largest magnitude in radix r
  function automatic int unsigned digit_span(input logic [s2i_pkg::RADIX_W-1:0] r);
    logic [63:0] p;
    int unsigned k;
    if (r < 2) begin
      return 4;
    end
    p = 1;
    k = 0;
    while (p <= MAG_MAX) begin
      p = p * r;
      k++;
    end
    return k;
  endfunction

  function automatic void clear_parse();
    ps_phase  = PH_SPACE;
    ps_neg    = 1'b0;
    ps_mag    = '0;
    ps_failed = 1'b0;
  endfunction

  function automatic void take_digit(input logic [7:0] ch);
    logic [6:0] d;
    if (ps_failed) begin
      return;
    end
    ps_phase = PH_DIGITS;
    d = sym_value(ch);
    if (d >= cur_radix || ps_mag * cur_radix + d > MAG_MAX) begin
      ps_failed = 1'b1;
    end else begin
      ps_mag = ps_mag * cur_radix + d;
    end
  endfunction

  // Advance the parser by one accepted character; queue a result on a terminator
  function automatic void parse_char(input logic [7:0] ch);
    conv_result_t r;
    logic [31:0] low;
    if (ch == s2i_pkg::CH_NUL) begin
      low = ps_mag[31:0];
      r.bad = ps_failed || (ps_phase != PH_DIGITS);
      r.value = r.bad ? ERR_VALUE : (ps_neg ? -low : low);
      pending_results.push_back(r);
      clear_parse();
      return;
    end
    case (ps_phase)
      PH_SPACE: begin
        if (is_blank(ch)) begin
          // hold in whitespace
        end else if (ch == s2i_pkg::CH_PLUS) begin
          ps_phase = PH_PLUS;
        end else if (ch == s2i_pkg::CH_MINUS) begin
          ps_phase = PH_MINUS;
          ps_neg = 1'b1;
        end else begin
          take_digit(ch);
        end
      end
      PH_PLUS: begin
        if (ch == s2i_pkg::CH_MINUS) begin
          ps_phase = PH_MINUS;
          ps_neg = 1'b1;
        end else begin
          take_digit(ch);
        end
      end
      default: take_digit(ch);
    endcase
  endfunction

  task automatic send_char(input logic [7:0] ch);
    int gap;
    gap = 0;
    if (!tx_calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
    end
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_char_code = ch;
    do @(posedge clk); while (in_stall);
    parse_char(ch);
    chars_sent++;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i]);
    end
    send_char(s2i_pkg::CH_NUL);
  endtask

  // Drop valid and hold until every result is back and the block has settled
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_radix(input logic [s2i_pkg::RADIX_W-1:0] v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_radix = v;
    @(posedge clk);
    cur_radix = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_digits(input int unsigned n);
    repeat (n) send_char(digit_sym($urandom_range(0, symbol_count(cur_radix) - 1)));
  endtask

  task automatic send_number_string();
    int unsigned kind;
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      repeat ($urandom_range(0, 2)) send_char(pick_blank());
      if ($urandom_range(0, 3) == 0) send_char(s2i_pkg::CH_PLUS);
      if ($urandom_range(0, 2) == 0) send_char(s2i_pkg::CH_MINUS);
      send_digits($urandom_range(1, digit_span(cur_radix) + 1));
    end else if (kind == 7) begin
      repeat ($urandom_range(0, 6)) send_char(8'($urandom_range(1, 255)));
    end else if (kind == 8) begin
      send_digits($urandom_range(1, 3));
      case ($urandom_range(0, 4))
        0: send_char(s2i_pkg::CH_SPACE);
        1: send_char(s2i_pkg::CH_PLUS);
        2: send_char(s2i_pkg::CH_MINUS);
        3: send_char(8'($urandom_range(128, 255)));
        default: begin
          if (cur_radix < 36) begin
            send_char(digit_sym($urandom_range(cur_radix, 35)));
          end else begin
            send_char(8'h2E);
          end
        end
      endcase
      send_digits($urandom_range(0, 2));
    end else begin
      if ($urandom_range(0, 1)) send_char(pick_blank());
      if ($urandom_range(0, 1)) begin
        send_char($urandom_range(0, 1) ? s2i_pkg::CH_PLUS : s2i_pkg::CH_MINUS);
      end
    end
    send_char(s2i_pkg::CH_NUL);
  endtask

  task automatic test_whitespace_sign();
    send_char(s2i_pkg::CH_TAB);
    send_char(s2i_pkg::CH_LF);
    send_char(s2i_pkg::CH_VT);
    send_char(s2i_pkg::CH_FF);
    send_char(s2i_pkg::CH_CR);
    send_str(" +-9");
    send_str("+42");
    wait_idle();
  endtask

  task automatic test_empty_strings();
    send_char(s2i_pkg::CH_NUL);
    send_str("-");
    send_str(" +");
    wait_idle();
  endtask

  task automatic test_bad_chars();
    send_str("1 5");
    send_str("-+3");
    send_char(CH_ONE_HELPER);
    send_char(8'hFF);
    send_str("2");
    send_str("9x");
    wait_idle();
  endtask

  task automatic test_radix_limits();
    write_radix(6'd36);
    send_str("ZIK0ZJ");
    send_str("zik0zk");
    wait_idle();
    write_radix(6'd2);
    send_str("-10");
    send_str("2");
    wait_idle();
    write_radix(6'd0);
    send_str("0");
    wait_idle();
    write_radix(6'd1);
    send_str("0");
    send_str("1");
    wait_idle();
    write_radix(6'd63);
    send_str("zZ");
    wait_idle();
  endtask

  task automatic test_radix_midstring();
    write_radix(6'd10);
    send_char(s2i_pkg::CH_ZERO + 8'd7);
    wait_idle();
    write_radix(6'd16);
    send_char(s2i_pkg::CH_LC_A + 8'd5);
    send_char(s2i_pkg::CH_NUL);
    wait_idle();
  endtask

  task automatic test_random_radix_sweep();
    logic [s2i_pkg::RADIX_W-1:0] plan[10];
    int budget;
    plan[0] = 6'd10;
    plan[1] = 6'd16;
    plan[2] = 6'd2;
    plan[3] = 6'd36;
    plan[4] = 6'd8;
    plan[5] = 6'($urandom_range(3, 35));
    plan[6] = 6'($urandom_range(3, 35));
    plan[7] = 6'd0;
    plan[8] = 6'd1;
    plan[9] = 6'($urandom_range(37, 63));
    for (int i = 0; i < 10; i++) begin
      wait_idle();
      write_radix(plan[i]);
      budget = chars_sent + ((plan[i] >= 2 && plan[i] <= 36) ? 105 : 35);
      while (chars_sent < budget) send_number_string();
    end
    wait_idle();
  endtask

  // Hold the output long enough that both result slots fill and input stalls
  task automatic test_output_backpressure();
    int budget;
    write_radix(6'd10);
    tx_calm = 1'b1;
    rx_hold_left = 150;
    budget = chars_sent + 90;
    while (chars_sent < budget) begin
      send_digits(1);
      send_char(s2i_pkg::CH_NUL);
    end
    tx_calm = 1'b0;
    wait_idle();
  endtask

  task automatic test_streaming_no_idle();
    int budget;
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    write_radix(6'd16);
    budget = chars_sent + 120;
    while (chars_sent < budget) send_number_string();
    wait_idle();
  endtask

  // Result acceptance and comparison
  initial begin : result_check
    conv_result_t exp_r;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result with no pending request: value %0d bad %0b", out_value, out_bad);
          mismatches++;
        end else begin
          exp_r = pending_results.pop_front();
          if (out_value !== exp_r.value) begin
            $error("value: expected %0d, got %0d", exp_r.value, out_value);
            mismatches++;
          end
          if (out_bad !== exp_r.bad) begin
            $error("bad: expected %0b, got %0b", exp_r.bad, out_bad);
            mismatches++;
          end
        end
      end
    end
  end

  // Output stall: random bursts, a counted long hold, or none when calm
  initial begin : result_stall
    int burst;
    bit burst_stall;
    burst = 0;
    burst_stall = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_left > 0) begin
        out_stall = 1'b1;
        rx_hold_left--;
      end else if (rx_calm) begin
        out_stall = 1'b0;
      end else begin
        if (burst == 0) begin
          burst_stall = ($urandom_range(0, 2) == 0);
          burst = burst_stall ? $urandom_range(1, 18) : $urandom_range(1, 30);
        end
        out_stall = burst_stall;
        burst--;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_radix = s2i_pkg::RADIX_RESET;
    in_valid = 1'b0;
    in_char_code = '0;
    mismatches = 0;
    chars_sent = 0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    rx_hold_left = 0;
    cur_radix = s2i_pkg::RADIX_RESET;
    clear_parse();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_whitespace_sign();
    test_empty_strings();
    test_bad_chars();
    test_radix_limits();
    test_radix_midstring();
    test_random_radix_sweep();
    test_output_backpressure();
    test_streaming_no_idle();

    if (mismatches == 0) begin
      $display("** string_to_integer_radix: PASSED **");
    end else begin
      $display("** string_to_integer_radix: FAILED **");
    end
    $finish;
  end

endmodule
